### rtl/core/dats_pkg.sv
// Package for the dependency-aware task scheduler: sizes, codes, beat payloads
// and the sequencer state type. Depends on nothing.
package dats_pkg;

	localparam int SLOTS    = 64;
	localparam int MAX_DEPS = 16;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int DEP_AW   = $clog2(MAX_DEPS);
	localparam int HW       = 64;
	localparam int CNT_W    = 5;
	localparam int PRIO_W   = 2;

	typedef enum logic [2:0] {
		OP_SUBMIT   = 3'd0,
		OP_DEP      = 3'd1,
		OP_TAKE     = 3'd2,
		OP_COMPLETE = 3'd3,
		OP_QUERY    = 3'd4
	} op_t;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_REJECT  = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [PRIO_W-1:0] priority_req;
		logic [CNT_W-1:0]  dependency_count;
		logic [HW-1:0]     dep_handle;
		logic [HW-1:0]     query_handle;
		logic [5:0]        done_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [HW-1:0] job_handle;
		logic [5:0]    job_slot;
		logic          is_complete;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [CNT_W-1:0]  cnt;
	} slot_info_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FREE_SCAN,
		ST_COMMIT,
		ST_TAKE_SLOT,
		ST_TAKE_PC,
		ST_TAKE_DEP,
		ST_TAKE_DEPD,
		ST_LIVE_RD,
		ST_LIVE_CMP,
		ST_TAKE_HRD,
		ST_TAKE_FIN,
		ST_RESP
	} state_t;

endpackage

### rtl/core/dats_stream_if.sv
// Valid/ready stream interface carrying one beat of a payload type.
// Used with the beat structs of dats_pkg.
interface dats_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/dats_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dats_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/dependency_aware_task_scheduler_core.sv
// Take can run longest: for every dependency checked, a live-handle scan reads the
// handle RAM slot by slot to see whether that handle is still live. One item is
// handled at a time; a dependency beat that does not finish a submit is taken back
// to back. Reset clears slot state bits, the beat counter and pending state, and sets
// the handle counter to 1; the RAMs need no clearing pass since only written entries
// are ever read.
module dependency_aware_task_scheduler_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	dats_stream_if.sink   req,
	dats_stream_if.source rsp
);
	localparam int DAW = dats_pkg::SLOT_W + dats_pkg::DEP_AW;
	localparam int SW  = dats_pkg::SLOT_W;

	// Slot state: a live bit (queued or running) and a running bit per slot.
	logic [dats_pkg::SLOTS-1:0] live_q, live_d, run_q, run_d;

	dats_pkg::state_t state_q, state_d;

	// Pending submission.
	logic                        pa_q, pa_d;
	logic [dats_pkg::PRIO_W-1:0] pp_q, pp_d;
	logic [dats_pkg::CNT_W-1:0]  pc_q, pc_d, recv_q, recv_d;
	logic [SW-1:0]               dest_q, dest_d;
	logic                        dok_q, dok_d;
	logic [dats_pkg::HW-1:0]     nh_q, nh_d;
	logic                        shutting_down_q;

	// Scan registers for submit, take and query.
	logic [SW:0]                 scan_q, scan_d, slot_q, slot_d;
	logic [dats_pkg::CNT_W-1:0]  dep_q, dep_d, cc_q, cc_d;
	logic [dats_pkg::HW-1:0]     key_q, key_d;
	logic                        qm_q, qm_d, found_q, found_d;
	logic [SW-1:0]               best_q, best_d;
	logic [dats_pkg::PRIO_W-1:0] bp_q, bp_d, cp_q, cp_d;

	dats_pkg::rsp_t res_q, res_d, out_q;
	logic           out_valid_q;
	logic           out_ld;

	logic                    acc, commit_ok, scan_done, scan_hit;
	logic [SW-1:0]           ds_idx;
	dats_pkg::slot_info_t    i_rdata, i_wdata;
	logic [dats_pkg::HW-1:0] h_rdata, d_rdata;
	logic                    h_we, d_we;
	logic [SW-1:0]           h_raddr;
	logic [DAW-1:0]          d_waddr, d_raddr;

	assign acc       = req.valid & req.ready;
	assign req.ready = (state_q == dats_pkg::ST_IDLE);
	assign commit_ok = dok_q & ~shutting_down_q;
	assign ds_idx    = SW'(req.data.done_slot);

	// Handle RAM: one handle per slot, read during live scans and for the taken job.
	assign h_we    = (state_q == dats_pkg::ST_COMMIT) & commit_ok;
	assign h_raddr = (state_q == dats_pkg::ST_TAKE_HRD) ? best_q : scan_q[SW-1:0];

	dats_ram #(.DEPTH(dats_pkg::SLOTS), .WIDTH(dats_pkg::HW)) u_handle_ram (
		.clk(clk), .we(h_we), .waddr(dest_q), .wdata(nh_q),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	// Priority and dependency count per slot, written with the handle.
	assign i_wdata.prio = pp_q;
	assign i_wdata.cnt  = pc_q;

	dats_ram #(.DEPTH(dats_pkg::SLOTS), .WIDTH($bits(dats_pkg::slot_info_t))) u_info_ram (
		.clk(clk), .we(h_we), .waddr(dest_q), .wdata(i_wdata),
		.raddr(slot_q[SW-1:0]), .rdata(i_rdata)
	);

	// Dependency handles, written straight into the destination slot's row as they
	// arrive. The row belongs to a free slot until commit, so a dropped submit
	// leaves nothing visible behind.
	assign d_we    = acc & (req.data.opcode == dats_pkg::OP_DEP) & pa_q & dok_q;
	assign d_waddr = {dest_q, recv_q[dats_pkg::DEP_AW-1:0]};
	assign d_raddr = {slot_q[SW-1:0], dep_q[dats_pkg::DEP_AW-1:0]};

	dats_ram #(.DEPTH(dats_pkg::SLOTS * dats_pkg::MAX_DEPS), .WIDTH(dats_pkg::HW)) u_dep_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(req.data.dep_handle),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	always_comb begin
		state_d   = state_q;
		live_d    = live_q;
		run_d     = run_q;
		pa_d      = pa_q;
		pp_d      = pp_q;
		pc_d      = pc_q;
		recv_d    = recv_q;
		dest_d    = dest_q;
		dok_d     = dok_q;
		nh_d      = nh_q;
		scan_d    = scan_q;
		slot_d    = slot_q;
		dep_d     = dep_q;
		cc_d      = cc_q;
		key_d     = key_q;
		qm_d      = qm_q;
		found_d   = found_q;
		best_d    = best_q;
		bp_d      = bp_q;
		cp_d      = cp_q;
		res_d     = res_q;
		scan_done = 1'b0;
		scan_hit  = 1'b0;

		unique case (state_q)
			dats_pkg::ST_IDLE: begin
				if (acc) begin
					// Anything but a dependency beat drops a pending submit.
					if (req.data.opcode != dats_pkg::OP_DEP) begin
						pa_d = 1'b0;
					end
					res_d = '0;
					unique case (req.data.opcode)
						dats_pkg::OP_SUBMIT: begin
							if (req.data.dependency_count >
							    dats_pkg::CNT_W'(dats_pkg::MAX_DEPS)) begin
								res_d.status = dats_pkg::STAT_REJECT;
								state_d      = dats_pkg::ST_RESP;
							end else begin
								pp_d    = req.data.priority_req;
								pc_d    = req.data.dependency_count;
								recv_d  = '0;
								scan_d  = '0;
								state_d = dats_pkg::ST_FREE_SCAN;
							end
						end
						dats_pkg::OP_DEP: begin
							if (!pa_q) begin
								res_d.status = dats_pkg::STAT_IGNORED;
								state_d      = dats_pkg::ST_RESP;
							end else begin
								recv_d = recv_q + 1'b1;
								if (recv_q + 1'b1 >= pc_q) begin
									pa_d    = 1'b0;
									state_d = dats_pkg::ST_COMMIT;
								end
							end
						end
						dats_pkg::OP_TAKE: begin
							slot_d  = '0;
							found_d = 1'b0;
							state_d = dats_pkg::ST_TAKE_SLOT;
						end
						dats_pkg::OP_COMPLETE: begin
							if (32'(req.data.done_slot) < dats_pkg::SLOTS && run_q[ds_idx]) begin
								live_d[ds_idx] = 1'b0;
								run_d[ds_idx]  = 1'b0;
								res_d.status   = dats_pkg::STAT_DONE;
							end else begin
								res_d.status = dats_pkg::STAT_IGNORED;
							end
							state_d = dats_pkg::ST_RESP;
						end
						dats_pkg::OP_QUERY: begin
							if (req.data.query_handle == '0) begin
								res_d.is_complete = 1'b1;
								state_d           = dats_pkg::ST_RESP;
							end else begin
								key_d   = req.data.query_handle;
								qm_d    = 1'b1;
								scan_d  = '0;
								state_d = dats_pkg::ST_LIVE_RD;
							end
						end
						default: begin
							res_d.status = dats_pkg::STAT_IGNORED;
							state_d      = dats_pkg::ST_RESP;
						end
					endcase
				end
			end
			dats_pkg::ST_FREE_SCAN: begin
				if (scan_q == (SW+1)'(dats_pkg::SLOTS) || !live_q[scan_q[SW-1:0]]) begin
					dok_d  = (scan_q != (SW+1)'(dats_pkg::SLOTS));
					dest_d = scan_q[SW-1:0];
					if (pc_q == '0) begin
						state_d = dats_pkg::ST_COMMIT;
					end else begin
						pa_d    = 1'b1;
						state_d = dats_pkg::ST_IDLE;
					end
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			dats_pkg::ST_COMMIT: begin
				res_d = '0;
				if (commit_ok) begin
					live_d[dest_q]   = 1'b1;
					run_d[dest_q]    = 1'b0;
					res_d.job_handle = nh_q;
					nh_d             = (nh_q + 1'b1 == '0) ? dats_pkg::HW'(1) : nh_q + 1'b1;
				end else begin
					res_d.status = dats_pkg::STAT_REJECT;
				end
				state_d = dats_pkg::ST_RESP;
			end
			dats_pkg::ST_TAKE_SLOT: begin
				if (slot_q == (SW+1)'(dats_pkg::SLOTS)) begin
					if (found_q) begin
						state_d = dats_pkg::ST_TAKE_HRD;
					end else begin
						res_d        = '0;
						res_d.status = dats_pkg::STAT_REJECT;
						state_d      = dats_pkg::ST_RESP;
					end
				end else if (live_q[slot_q[SW-1:0]] && !run_q[slot_q[SW-1:0]]) begin
					state_d = dats_pkg::ST_TAKE_PC;
				end else begin
					slot_d = slot_q + 1'b1;
				end
			end
			dats_pkg::ST_TAKE_PC: begin
				// A slot that cannot beat the current best needs no dependency check.
				if (found_q && i_rdata.prio <= bp_q) begin
					slot_d  = slot_q + 1'b1;
					state_d = dats_pkg::ST_TAKE_SLOT;
				end else begin
					cp_d    = i_rdata.prio;
					cc_d    = i_rdata.cnt;
					dep_d   = '0;
					state_d = dats_pkg::ST_TAKE_DEP;
				end
			end
			dats_pkg::ST_TAKE_DEP: begin
				if (dep_q >= cc_q) begin
					best_d  = slot_q[SW-1:0];
					bp_d    = cp_q;
					found_d = 1'b1;
					slot_d  = slot_q + 1'b1;
					state_d = dats_pkg::ST_TAKE_SLOT;
				end else begin
					state_d = dats_pkg::ST_TAKE_DEPD;
				end
			end
			dats_pkg::ST_TAKE_DEPD: begin
				key_d   = d_rdata;
				qm_d    = 1'b0;
				scan_d  = '0;
				state_d = dats_pkg::ST_LIVE_RD;
			end
			dats_pkg::ST_LIVE_RD: begin
				if (scan_q == (SW+1)'(dats_pkg::SLOTS)) begin
					scan_done = 1'b1;
				end else if (live_q[scan_q[SW-1:0]]) begin
					state_d = dats_pkg::ST_LIVE_CMP;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			dats_pkg::ST_LIVE_CMP: begin
				if (h_rdata == key_q) begin
					scan_done = 1'b1;
					scan_hit  = 1'b1;
				end else begin
					scan_d  = scan_q + 1'b1;
					state_d = dats_pkg::ST_LIVE_RD;
				end
			end
			dats_pkg::ST_TAKE_HRD: begin
				state_d = dats_pkg::ST_TAKE_FIN;
			end
			dats_pkg::ST_TAKE_FIN: begin
				run_d[best_q]    = 1'b1;
				res_d            = '0;
				res_d.job_handle = h_rdata;
				res_d.job_slot   = 6'(best_q);
				state_d          = dats_pkg::ST_RESP;
			end
			dats_pkg::ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = dats_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dats_pkg::ST_IDLE;
			end
		endcase

		// End of a live-handle scan: answer a query, or move on in the take walk.
		if (scan_done) begin
			if (qm_q) begin
				res_d             = '0;
				res_d.is_complete = ~scan_hit;
				state_d           = dats_pkg::ST_RESP;
			end else if (scan_hit) begin
				slot_d  = slot_q + 1'b1;
				state_d = dats_pkg::ST_TAKE_SLOT;
			end else begin
				dep_d   = dep_q + 1'b1;
				state_d = dats_pkg::ST_TAKE_DEP;
			end
		end
	end

	assign out_ld = (state_q == dats_pkg::ST_RESP) & (~out_valid_q | rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= dats_pkg::ST_IDLE;
			live_q          <= '0;
			run_q           <= '0;
			pa_q            <= 1'b0;
			pp_q            <= '0;
			pc_q            <= '0;
			recv_q          <= '0;
			dok_q           <= 1'b0;
			nh_q            <= dats_pkg::HW'(1);
			shutting_down_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			live_q   <= live_d;
			run_q    <= run_d;
			pa_q     <= pa_d;
			pp_q     <= pp_d;
			pc_q     <= pc_d;
			recv_q   <= recv_d;
			dok_q    <= dok_d;
			nh_q     <= nh_d;
			if (cfg_we) begin
				shutting_down_q <= cfg_wdata;
			end
			out_valid_q <= out_ld | (out_valid_q & ~rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		dest_q  <= dest_d;
		scan_q  <= scan_d;
		slot_q  <= slot_d;
		dep_q   <= dep_d;
		cc_q    <= cc_d;
		key_q   <= key_d;
		qm_q    <= qm_d;
		found_q <= found_d;
		best_q  <= best_d;
		bp_q    <= bp_d;
		cp_q    <= cp_d;
		res_q   <= res_d;
		if (out_ld) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
endmodule

### rtl/core/dats_checker.sv
// Port-level checker for the task scheduler core, bound into the core module.
// Depends on dats_pkg for the status codes.
module dats_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [63:0] rsp_handle,
	input logic [5:0]  rsp_slot,
	input logic        rsp_complete
);
	// A stalled result beat stays valid with its handle and status held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_handle) && $stable(rsp_status))
		else $error("stalled result beat changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != 2'd3)
		else $error("undefined status code");

	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == dats_pkg::STAT_IGNORED |->
		rsp_handle == 64'd0 && rsp_slot == 6'd0 && !rsp_complete)
		else $error("ignored beat carries data");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == dats_pkg::STAT_REJECT |->
		rsp_handle == 64'd0 && rsp_slot == 6'd0)
		else $error("rejected beat carries a handle");
endmodule

bind dependency_aware_task_scheduler_core dats_checker u_dats_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.data.status),
	.rsp_handle   (rsp.data.job_handle),
	.rsp_slot     (rsp.data.job_slot),
	.rsp_complete (rsp.data.is_complete)
);
